FILE: rtl/bpc_pkg.sv
package bpc_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned CFG_IDX_W = 4;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_AC1 = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AC2 = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AC3 = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AC4 = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AC5_AC6 = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MC_MD = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_B1_B2 = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_OSS = 4'd7;

    // reset values of the calibration set
    localparam logic [15:0] RST_AC1 = 16'd408;
    localparam logic [15:0] RST_AC2 = 16'hFFB8;
    localparam logic [15:0] RST_AC3 = 16'hC7D1;
    localparam logic [15:0] RST_AC4 = 16'd32741;
    localparam logic [31:0] RST_AC5_AC6 = 32'h7FF5_5A71;
    localparam logic [31:0] RST_MC_MD = 32'hDDF9_0B34;
    localparam logic [31:0] RST_B1_B2 = 32'h182E_0004;
    localparam logic [1:0] RST_OSS = 2'd0;

    // compensation constants
    localparam logic [31:0] B6_OFFSET = 32'd4000;
    localparam logic [31:0] T_ROUND = 32'd8;
    localparam logic [31:0] P_SQ_COEF = 32'd3038;
    localparam logic [31:0] P_LIN_COEF = 32'hFFFF_E343;
    localparam logic [31:0] P_OFFSET = 32'd3791;
    localparam logic [31:0] B7_SCALE = 32'd50000;
    localparam logic [31:0] B4_BIAS = 32'd32768;

    typedef struct packed {
        logic [15:0] ac1;
        logic [15:0] ac2;
        logic [15:0] ac3;
        logic [15:0] ac4;
        logic [15:0] ac5;
        logic [15:0] ac6;
        logic [15:0] mc;
        logic [15:0] md;
        logic [15:0] b1;
        logic [15:0] b2;
        logic [1:0] oss;
    } cal_t;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
        return 32'($signed(x) >>> n);
    endfunction

endpackage

FILE: rtl/bpc_cfg.sv
module bpc_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                    cfg_data,
    output bpc_pkg::cal_t                  cal
);

    bpc_pkg::cal_t cal_reg;
    bpc_pkg::cal_t cal_next;

    assign cfg_ready = 1'b1;
    assign cal = cal_reg;

    always_comb
    begin
        cal_next = cal_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                bpc_pkg::REG_AC1: cal_next.ac1 = cfg_data[15:0];
                bpc_pkg::REG_AC2: cal_next.ac2 = cfg_data[15:0];
                bpc_pkg::REG_AC3: cal_next.ac3 = cfg_data[15:0];
                bpc_pkg::REG_AC4: cal_next.ac4 = cfg_data[15:0];
                bpc_pkg::REG_AC5_AC6:
                begin
                    cal_next.ac5 = cfg_data[31:16];
                    cal_next.ac6 = cfg_data[15:0];
                end
                bpc_pkg::REG_MC_MD:
                begin
                    cal_next.mc = cfg_data[31:16];
                    cal_next.md = cfg_data[15:0];
                end
                bpc_pkg::REG_B1_B2:
                begin
                    cal_next.b1 = cfg_data[31:16];
                    cal_next.b2 = cfg_data[15:0];
                end
                bpc_pkg::REG_OSS: cal_next.oss = cfg_data[1:0];
                default: cal_next = cal_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg.ac1 <= bpc_pkg::RST_AC1;
            cal_reg.ac2 <= bpc_pkg::RST_AC2;
            cal_reg.ac3 <= bpc_pkg::RST_AC3;
            cal_reg.ac4 <= bpc_pkg::RST_AC4;
            cal_reg.ac5 <= bpc_pkg::RST_AC5_AC6[31:16];
            cal_reg.ac6 <= bpc_pkg::RST_AC5_AC6[15:0];
            cal_reg.mc <= bpc_pkg::RST_MC_MD[31:16];
            cal_reg.md <= bpc_pkg::RST_MC_MD[15:0];
            cal_reg.b1 <= bpc_pkg::RST_B1_B2[31:16];
            cal_reg.b2 <= bpc_pkg::RST_B1_B2[15:0];
            cal_reg.oss <= bpc_pkg::RST_OSS;
        end
        else
        begin
            cal_reg <= cal_next;
        end
    end

endmodule

FILE: rtl/bpc_div.sv
module bpc_div #(
    parameter int unsigned W = 32,
    parameter int unsigned PW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_vld,
    input  logic [W-1:0]  dividend,
    input  logic [W-1:0]  divisor,
    input  logic [PW-1:0] in_pay,
    output logic          out_vld,
    output logic [W-1:0]  quotient,
    output logic [PW-1:0] out_pay
);

    // one quotient bit per stage, restoring
    logic [W-1:0]  rem_reg [0:W-1];
    logic [W-1:0]  quo_reg [0:W-1];
    logic [W-1:0]  num_reg [0:W-1];
    logic [W-1:0]  den_reg [0:W-1];
    logic [PW-1:0] pay_reg [0:W-1];
    logic [W-1:0]  vld_reg;

    genvar k;
    generate
        for (k = 0; k < W; k++)
        begin : g_stage
            logic [W-1:0]  rem_in;
            logic [W-1:0]  quo_in;
            logic [W-1:0]  num_in;
            logic [W-1:0]  den_in;
            logic [PW-1:0] pay_in;
            logic          vld_in;
            logic [W:0]    trial;
            logic          ge;
            logic [W-1:0]  rem_next;

            if (k == 0)
            begin : g_first
                assign rem_in = '0;
                assign quo_in = '0;
                assign num_in = dividend;
                assign den_in = divisor;
                assign pay_in = in_pay;
                assign vld_in = in_vld;
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[k-1];
                assign quo_in = quo_reg[k-1];
                assign num_in = num_reg[k-1];
                assign den_in = den_reg[k-1];
                assign pay_in = pay_reg[k-1];
                assign vld_in = vld_reg[k-1];
            end

            always_comb
            begin
                trial = {rem_in, num_in[W-1-k]};
                ge = (trial >= {1'b0, den_in});
                rem_next = ge ? W'(trial - {1'b0, den_in}) : trial[W-1:0];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= rem_next;
                    quo_reg[k] <= {quo_in[W-2:0], ge};
                    num_reg[k] <= num_in;
                    den_reg[k] <= den_in;
                    pay_reg[k] <= pay_in;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[k] <= 1'b0;
                else if (en)
                    vld_reg[k] <= vld_in;
            end
        end
    endgenerate

    assign out_vld = vld_reg[W-1];
    assign quotient = quo_reg[W-1];
    assign out_pay = pay_reg[W-1];

endmodule

FILE: rtl/barometric_pressure_compensation_top.sv
// Pressure and temperature compensation for a barometric sensor: each request carries a raw
// temperature word and an aligned raw pressure word and yields B5+8 (1/160 degC units), the
// pressure in pascal and a flag for a zero divisor. The block accepts one request every cycle
// unless a valid output result is stalled, which freezes the pipeline and holds in_stall high;
// results pass 17 arithmetic stages and two 32-stage radix-2 divider pipelines.
// Calibration is written through the configuration port, always ready; the user must write it
// only while the block is idle, which the block itself does not enforce.
module barometric_pressure_compensation_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [15:0]                    raw_temperature,
    input  logic [18:0]                    raw_pressure,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [31:0]             temperature_fixed,
    output logic signed [31:0]             pressure_pa,
    output logic                           divide_error,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                    cfg_data
);

    localparam int unsigned DW = bpc_pkg::DATA_W;
    localparam int unsigned PW1 = DW + 19 + 2;
    localparam int unsigned PW2 = DW + 3;

    bpc_pkg::cal_t cal;

    // global advance: the pipeline moves unless the output holds a stalled result
    logic en;
    assign en = !(out_valid && out_stall);
    assign in_stall = !en;

    bpc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cal       (cal)
    );

    // calibration in 32-bit form
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, mc, md, b1, b2;
    assign ac1 = bpc_pkg::sx16(cal.ac1);
    assign ac2 = bpc_pkg::sx16(cal.ac2);
    assign ac3 = bpc_pkg::sx16(cal.ac3);
    assign ac4 = {16'b0, cal.ac4};
    assign ac5 = {16'b0, cal.ac5};
    assign ac6 = {16'b0, cal.ac6};
    assign mc = bpc_pkg::sx16(cal.mc);
    assign md = bpc_pkg::sx16(cal.md);
    assign b1 = bpc_pkg::sx16(cal.b1);
    assign b2 = bpc_pkg::sx16(cal.b2);

    // valid bits: front (A..D), middle (E..M), back (N..Q)
    logic [3:0] front_vld_reg;
    logic [8:0] mid_vld_reg;
    logic [3:0] back_vld_reg;
    logic       div1_vld, div2_vld;

    // stage A: capture request
    logic [15:0] a_ut_reg;
    logic [18:0] a_up_reg;
    // stage B: (ut - ac6) * ac5
    logic [31:0] b_prod_reg;
    logic [18:0] b_up_reg;
    // stage C: x1 = prod / 32768 toward zero
    logic [31:0] c_x1_reg;
    logic [18:0] c_up_reg;
    // stage D: divisor set-up for x2
    logic [31:0] d_x1_reg, d_ma_reg, d_mb_reg;
    logic [18:0] d_up_reg;
    logic        d_neg_reg, d_zero_reg;

    logic [31:0]    c_prod_adj;
    logic [31:0]    d_den, d_num;

    always_comb
    begin
        c_prod_adj = b_prod_reg + (b_prod_reg[31] ? 32'd32767 : 32'd0);
        d_den = c_x1_reg + md;
        d_num = {mc[20:0], 11'b0};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_ut_reg <= raw_temperature;
            a_up_reg <= raw_pressure;
            b_prod_reg <= 32'(({16'b0, a_ut_reg} - ac6) * ac5);
            b_up_reg <= a_up_reg;
            c_x1_reg <= bpc_pkg::asr(c_prod_adj, 15);
            c_up_reg <= b_up_reg;
            d_x1_reg <= c_x1_reg;
            d_up_reg <= c_up_reg;
            d_ma_reg <= d_num[31] ? 32'(32'd0 - d_num) : d_num;
            d_mb_reg <= d_den[31] ? 32'(32'd0 - d_den) : d_den;
            d_neg_reg <= d_num[31] ^ d_den[31];
            d_zero_reg <= (d_den == 32'd0);
        end
    end

    logic [31:0]    div1_q;
    logic [PW1-1:0] div1_pay;

    bpc_div #(.W(DW), .PW(PW1)) u_div_temp (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (front_vld_reg[3]),
        .dividend (d_ma_reg),
        .divisor  (d_mb_reg),
        .in_pay   ({d_x1_reg, d_up_reg, d_neg_reg, d_zero_reg}),
        .out_vld  (div1_vld),
        .quotient (div1_q),
        .out_pay  (div1_pay)
    );

    logic [31:0] q1_x1;
    logic [18:0] q1_up;
    logic        q1_neg, q1_zero;
    assign {q1_x1, q1_up, q1_neg, q1_zero} = div1_pay;

    // middle stages, z1 marks a zero temperature divisor
    logic [31:0] e_b5_reg;
    logic [18:0] e_up_reg;
    logic        e_z1_reg;
    logic [31:0] f_b6_reg, f_tmp_reg;
    logic [18:0] f_up_reg;
    logic        f_z1_reg;
    logic [31:0] g_sq_reg, g_ac2b6_reg, g_ac3b6_reg, g_tmp_reg;
    logic [18:0] g_up_reg;
    logic        g_z1_reg;
    logic [31:0] h_sq_reg, h_x2a_reg, h_x1b_reg, h_tmp_reg;
    logic [18:0] h_up_reg;
    logic        h_z1_reg;
    logic [31:0] i_m1_reg, i_m2_reg, i_x2a_reg, i_x1b_reg, i_tmp_reg;
    logic [18:0] i_up_reg;
    logic        i_z1_reg;
    logic [31:0] j_x3a_reg, j_x3b_reg, j_tmp_reg;
    logic [18:0] j_up_reg;
    logic        j_z1_reg;
    logic [31:0] k_b3_reg, k_b4p_reg, k_tmp_reg;
    logic [18:0] k_up_reg;
    logic        k_z1_reg;
    logic [31:0] l_b4_reg, l_b7_reg, l_tmp_reg;
    logic        l_z1_reg;
    logic [31:0] m_num_reg, m_b4_reg, m_tmp_reg;
    logic        m_z1_reg, m_z2_reg, m_sh_reg;

    logic [31:0] e_x2, j_x3b_sum, k_v, k_b3_adj;

    always_comb
    begin
        e_x2 = q1_neg ? 32'(32'd0 - div1_q) : div1_q;
        j_x3b_sum = i_x1b_reg + bpc_pkg::asr(i_m2_reg, 16) + 32'd2;
        k_v = 32'(((32'(ac1 << 2) + j_x3a_reg) << cal.oss) + 32'd2);
        k_b3_adj = k_v + (k_v[31] ? 32'd3 : 32'd0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_b5_reg <= q1_x1 + e_x2;
            e_up_reg <= q1_up;
            e_z1_reg <= q1_zero;

            f_b6_reg <= e_b5_reg - bpc_pkg::B6_OFFSET;
            f_tmp_reg <= e_b5_reg + bpc_pkg::T_ROUND;
            f_up_reg <= e_up_reg;
            f_z1_reg <= e_z1_reg;

            g_sq_reg <= 32'(f_b6_reg * f_b6_reg);
            g_ac2b6_reg <= 32'(ac2 * f_b6_reg);
            g_ac3b6_reg <= 32'(ac3 * f_b6_reg);
            g_tmp_reg <= f_tmp_reg;
            g_up_reg <= f_up_reg;
            g_z1_reg <= f_z1_reg;

            h_sq_reg <= bpc_pkg::asr(g_sq_reg, 12);
            h_x2a_reg <= bpc_pkg::asr(g_ac2b6_reg, 11);
            h_x1b_reg <= bpc_pkg::asr(g_ac3b6_reg, 13);
            h_tmp_reg <= g_tmp_reg;
            h_up_reg <= g_up_reg;
            h_z1_reg <= g_z1_reg;

            i_m1_reg <= 32'(b2 * h_sq_reg);
            i_m2_reg <= 32'(b1 * h_sq_reg);
            i_x2a_reg <= h_x2a_reg;
            i_x1b_reg <= h_x1b_reg;
            i_tmp_reg <= h_tmp_reg;
            i_up_reg <= h_up_reg;
            i_z1_reg <= h_z1_reg;

            j_x3a_reg <= bpc_pkg::asr(i_m1_reg, 11) + i_x2a_reg;
            j_x3b_reg <= bpc_pkg::asr(j_x3b_sum, 2);
            j_tmp_reg <= i_tmp_reg;
            j_up_reg <= i_up_reg;
            j_z1_reg <= i_z1_reg;

            k_b3_reg <= bpc_pkg::asr(k_b3_adj, 2);
            k_b4p_reg <= 32'(ac4 * (j_x3b_reg + bpc_pkg::B4_BIAS));
            k_tmp_reg <= j_tmp_reg;
            k_up_reg <= j_up_reg;
            k_z1_reg <= j_z1_reg;

            l_b4_reg <= k_b4p_reg >> 15;
            l_b7_reg <= 32'(({13'b0, k_up_reg} - k_b3_reg) * (bpc_pkg::B7_SCALE >> cal.oss));
            l_tmp_reg <= k_tmp_reg;
            l_z1_reg <= k_z1_reg;

            // large b7 divides first and doubles after
            m_num_reg <= l_b7_reg[31] ? l_b7_reg : {l_b7_reg[30:0], 1'b0};
            m_sh_reg <= l_b7_reg[31];
            m_b4_reg <= l_b4_reg;
            m_z2_reg <= (l_b4_reg == 32'd0);
            m_z1_reg <= l_z1_reg;
            m_tmp_reg <= l_tmp_reg;
        end
    end

    logic [31:0]    div2_q;
    logic [PW2-1:0] div2_pay;

    bpc_div #(.W(DW), .PW(PW2)) u_div_pres (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (mid_vld_reg[8]),
        .dividend (m_num_reg),
        .divisor  (m_b4_reg),
        .in_pay   ({m_tmp_reg, m_z1_reg, m_z2_reg, m_sh_reg}),
        .out_vld  (div2_vld),
        .quotient (div2_q),
        .out_pay  (div2_pay)
    );

    logic [31:0] q2_tmp;
    logic        q2_z1, q2_z2, q2_sh;
    assign {q2_tmp, q2_z1, q2_z2, q2_sh} = div2_pay;

    // back stages: final pressure correction
    logic [31:0] n_p_reg, n_t_reg, n_tmp_reg;
    logic        n_z1_reg, n_z2_reg;
    logic [31:0] o_p_reg, o_sqp_reg, o_m3_reg, o_tmp_reg;
    logic        o_z1_reg, o_z2_reg;
    logic [31:0] p_p_reg, p_x1m_reg, p_x2_reg, p_tmp_reg;
    logic        p_z1_reg, p_z2_reg;
    logic [31:0] q_tmp_reg, q_p_reg;
    logic        q_err_reg;

    logic [31:0] n_p, q_sum, q_p;

    always_comb
    begin
        n_p = q2_sh ? {div2_q[30:0], 1'b0} : div2_q;
        q_sum = bpc_pkg::asr(p_x1m_reg, 16) + p_x2_reg + bpc_pkg::P_OFFSET;
        q_p = p_p_reg + bpc_pkg::asr(q_sum, 4);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_p_reg <= n_p;
            n_t_reg <= bpc_pkg::asr(n_p, 8);
            n_tmp_reg <= q2_tmp;
            n_z1_reg <= q2_z1;
            n_z2_reg <= q2_z2;

            o_sqp_reg <= 32'(n_t_reg * n_t_reg);
            o_m3_reg <= 32'(bpc_pkg::P_LIN_COEF * n_p_reg);
            o_p_reg <= n_p_reg;
            o_tmp_reg <= n_tmp_reg;
            o_z1_reg <= n_z1_reg;
            o_z2_reg <= n_z2_reg;

            p_x1m_reg <= 32'(o_sqp_reg * bpc_pkg::P_SQ_COEF);
            p_x2_reg <= bpc_pkg::asr(o_m3_reg, 16);
            p_p_reg <= o_p_reg;
            p_tmp_reg <= o_tmp_reg;
            p_z1_reg <= o_z1_reg;
            p_z2_reg <= o_z2_reg;

            // zero temperature divisor clears both results, zero pressure divisor clears pressure
            q_tmp_reg <= p_z1_reg ? 32'd0 : p_tmp_reg;
            q_p_reg <= (p_z1_reg || p_z2_reg) ? 32'd0 : q_p;
            q_err_reg <= p_z1_reg || p_z2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_vld_reg <= '0;
            mid_vld_reg <= '0;
            back_vld_reg <= '0;
        end
        else if (en)
        begin
            front_vld_reg <= {front_vld_reg[2:0], in_valid};
            mid_vld_reg <= {mid_vld_reg[7:0], div1_vld};
            back_vld_reg <= {back_vld_reg[2:0], div2_vld};
        end
    end

    assign out_valid = back_vld_reg[3];
    assign temperature_fixed = $signed(q_tmp_reg);
    assign pressure_pa = $signed(q_p_reg);
    assign divide_error = q_err_reg;

endmodule

FILE: verif/bpc_checker.sv
`timescale 1ns / 100ps
module bpc_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [15:0]                   raw_temperature,
    input  logic [18:0]                   raw_pressure,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic signed [31:0]            temperature_fixed,
    input  logic signed [31:0]            pressure_pa,
    input  logic                          divide_error,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [bpc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data,
    output int                            fail_count,
    output int                            pending_count
);

    typedef struct packed {
        logic [31:0] temp;
        logic [31:0] pres;
        logic        derr;
    } comp_t;

    comp_t       comp_q[$];
    logic [15:0] m_ac1, m_ac2, m_ac3, m_ac4;
    logic [31:0] m_ac56, m_mcmd, m_b1b2;
    logic [1:0]  m_oss;

    // sign-extending arithmetic shift
    function automatic logic [31:0] sra32(logic [31:0] x, int n);
        return $signed(x) >>> n;
    endfunction

    // divide truncating toward zero, b nonzero
    function automatic logic [31:0] div_tz(logic [31:0] a, logic [31:0] b);
        logic [31:0] ma, mb, q;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q = ma / mb;
        if (a[31] ^ b[31]) q = -q;
        return q;
    endfunction

    function automatic logic [31:0] ext16(logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic comp_t compensate(logic [15:0] ut, logic [18:0] up);
        comp_t r;
        logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, mc, md, b1, b2;
        logic [31:0] x1, x2, x3, den, b5, b6, sq, b3, b4, b7, p;
        ac1 = ext16(m_ac1); ac2 = ext16(m_ac2); ac3 = ext16(m_ac3);
        ac4 = {16'd0, m_ac4};
        ac5 = {16'd0, m_ac56[31:16]}; ac6 = {16'd0, m_ac56[15:0]};
        mc = ext16(m_mcmd[31:16]); md = ext16(m_mcmd[15:0]);
        b1 = ext16(m_b1b2[31:16]); b2 = ext16(m_b1b2[15:0]);
        r = '0;
        x1 = div_tz(({16'd0, ut} - ac6) * ac5, 32'd32768);
        den = x1 + md;
        if (den == 0) begin
            r.derr = 1'b1;
            return r;
        end
        x2 = div_tz(mc * 32'd2048, den);
        b5 = x1 + x2;
        r.temp = b5 + 32'd8;
        b6 = b5 - 32'd4000;
        sq = sra32(b6 * b6, 12);
        x1 = sra32(b2 * sq, 11);
        x2 = sra32(ac2 * b6, 11);
        x3 = x1 + x2;
        b3 = div_tz(((ac1 * 32'd4 + x3) << m_oss) + 32'd2, 32'd4);
        x1 = sra32(ac3 * b6, 13);
        x2 = sra32(b1 * sq, 16);
        x3 = sra32(x1 + x2 + 32'd2, 2);
        b4 = (ac4 * (x3 + 32'd32768)) >> 15;
        b7 = ({13'd0, up} - b3) * (32'd50000 >> m_oss);
        if (b4 == 0) begin
            r.derr = 1'b1;
            return r;
        end
        if (!b7[31]) p = (b7 * 32'd2) / b4;
        else p = (b7 / b4) * 32'd2;
        x1 = sra32(p, 8) * sra32(p, 8);
        x1 = sra32(x1 * 32'd3038, 16);
        x2 = sra32((32'd0 - 32'd7357) * p, 16);
        r.pres = p + sra32(x1 + x2 + 32'd3791, 4);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        comp_t e;
        if (!rst_n)
        begin
            m_ac1 = bpc_pkg::RST_AC1; m_ac2 = bpc_pkg::RST_AC2;
            m_ac3 = bpc_pkg::RST_AC3; m_ac4 = bpc_pkg::RST_AC4;
            m_ac56 = bpc_pkg::RST_AC5_AC6; m_mcmd = bpc_pkg::RST_MC_MD;
            m_b1b2 = bpc_pkg::RST_B1_B2; m_oss = bpc_pkg::RST_OSS;
            comp_q.delete();
            fail_count = 0;
            pending_count = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (comp_q.size() == 0)
                    report_mismatch("unexpected result", temperature_fixed, 32'd0);
                else
                begin
                    e = comp_q.pop_front();
                    if (divide_error !== e.derr)
                        report_mismatch("divide_error", {31'd0, divide_error},
                                        {31'd0, e.derr});
                    // with a temperature divide error both fields are zero too
                    if (temperature_fixed !== e.temp)
                        report_mismatch("temperature_fixed", temperature_fixed, e.temp);
                    if (pressure_pa !== e.pres)
                        report_mismatch("pressure_pa", pressure_pa, e.pres);
                end
            end
            if (in_valid && !in_stall)
                comp_q.push_back(compensate(raw_temperature, raw_pressure));
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    bpc_pkg::REG_AC1:     m_ac1 = cfg_data[15:0];
                    bpc_pkg::REG_AC2:     m_ac2 = cfg_data[15:0];
                    bpc_pkg::REG_AC3:     m_ac3 = cfg_data[15:0];
                    bpc_pkg::REG_AC4:     m_ac4 = cfg_data[15:0];
                    bpc_pkg::REG_AC5_AC6: m_ac56 = cfg_data;
                    bpc_pkg::REG_MC_MD:   m_mcmd = cfg_data;
                    bpc_pkg::REG_B1_B2:   m_b1b2 = cfg_data;
                    bpc_pkg::REG_OSS:     m_oss = cfg_data[1:0];
                    default: ;
                endcase
            end
            pending_count = comp_q.size();
        end
    end
endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
module tb;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [15:0] raw_temperature = '0;
    logic [18:0] raw_pressure = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic signed [31:0] temperature_fixed;
    logic signed [31:0] pressure_pa;
    logic        divide_error;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [bpc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    int          fail_count;
    int          pending_count;
    int          cycle_count = 0;
    bit          hold_off = 1'b0;    // long receiver hold-off in progress
    bit          stall_enable = 1'b0;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 100;   // exceeds the block latency

    // clock of 8 ns period
    always #4 clk = ~clk;

    barometric_pressure_compensation_top uut (.*);

    bpc_checker chk (.*);

    // give up if the run never drains
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // receiver side: random stalls, plus one long hold-off when asked
    initial
    begin
        int n;
        forever
        begin
            @(negedge clk);
            if (hold_off)
                out_stall <= 1'b1;
            else if (!stall_enable)
                out_stall <= 1'b0;
            else
            begin
                n = gap_len();
                if (n == 0)
                    out_stall <= 1'b0;
                else
                begin
                    out_stall <= 1'b1;
                    repeat (n - 1) @(negedge clk);
                end
            end
        end
    end

    // long hold-off counted in its own process so the pipeline fills up
    task automatic long_hold_off();
        hold_off = 1'b1;
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
    endtask

    // one request: raise valid at a falling edge, wait for acceptance, then gap
    task automatic send_request(logic [15:0] ut, logic [18:0] up, bit gaps);
        int n;
        @(negedge clk);
        in_valid <= 1'b1;
        raw_temperature <= ut;
        raw_pressure <= up;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        n = gaps ? gap_len() : 0;
        if (n > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic end_burst();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // wait for every expected result, then allow for the tail of the pipeline
    task automatic drain();
        while (pending_count != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [bpc_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // typical datasheet-like calibration with a random spread, or fully random words when extreme
    task automatic load_calibration(bit extreme);
        if (extreme)
        begin
            write_reg(bpc_pkg::REG_AC1, $urandom());
            write_reg(bpc_pkg::REG_AC2, $urandom());
            write_reg(bpc_pkg::REG_AC3, $urandom());
            write_reg(bpc_pkg::REG_AC4, $urandom());
            write_reg(bpc_pkg::REG_AC5_AC6, $urandom());
            write_reg(bpc_pkg::REG_MC_MD, $urandom());
            write_reg(bpc_pkg::REG_B1_B2, $urandom());
        end
        else
        begin
            write_reg(bpc_pkg::REG_AC1,
                      32'(16'd408 + 16'($urandom_range(0, 2000)) - 16'd1000));
            write_reg(bpc_pkg::REG_AC2,
                      32'(16'hFFB8 + 16'($urandom_range(0, 200)) - 16'd100));
            write_reg(bpc_pkg::REG_AC3,
                      32'(16'hC7D1 + 16'($urandom_range(0, 4000)) - 16'd2000));
            write_reg(bpc_pkg::REG_AC4,
                      32'(16'd32741 + 16'($urandom_range(0, 2000)) - 16'd1000));
            write_reg(bpc_pkg::REG_AC5_AC6, {16'($urandom_range(20000, 40000)),
                                            16'($urandom_range(15000, 30000))});
            write_reg(bpc_pkg::REG_MC_MD, {16'hDDF9 + 16'($urandom_range(0, 400)),
                                          16'($urandom_range(1000, 5000))});
            write_reg(bpc_pkg::REG_B1_B2, {16'($urandom_range(5000, 7000)),
                                          16'($urandom_range(0, 100))});
        end
        write_reg(bpc_pkg::REG_OSS, $urandom_range(0, 3));
    endtask

    initial
    begin
        int phase;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset calibration, field extremes, every oversampling mode
        send_request(16'd27898, 19'd23843, 1'b0);
        send_request(16'h0000, 19'h00000, 1'b0);
        send_request(16'hFFFF, 19'h7FFFF, 1'b0);
        send_request(16'h0000, 19'h7FFFF, 1'b0);
        send_request(16'hFFFF, 19'h00000, 1'b0);
        send_request(16'h5555, 19'h2AAAA, 1'b0);
        send_request(16'hAAAA, 19'h55555, 1'b0);
        end_burst();
        drain();
        for (int m = 0; m < 4; m++)
        begin
            write_reg(bpc_pkg::REG_OSS, m);
            send_request(16'd27898, 19'd23843 << m, 1'b0);
            send_request(16'hFFFF, 19'h7FFFF, 1'b0);
            end_burst();
            drain();
        end

        // temperature divisor zero: ac5 = 0 gives x1 = 0, md = 0
        write_reg(bpc_pkg::REG_AC5_AC6, 32'h0000_5A71);
        write_reg(bpc_pkg::REG_MC_MD, 32'hDDF9_0000);
        send_request(16'd1234, 19'd5000, 1'b0);
        end_burst();
        drain();
        // pressure divisor zero: ac4 = 0 makes b4 zero
        write_reg(bpc_pkg::REG_MC_MD, bpc_pkg::RST_MC_MD);
        write_reg(bpc_pkg::REG_AC4, 32'd0);
        send_request(16'd1234, 19'd5000, 1'b0);
        end_burst();
        drain();
        // extreme coefficients: wrap-around everywhere
        write_reg(bpc_pkg::REG_AC1, 32'h8000);
        write_reg(bpc_pkg::REG_AC2, 32'h7FFF);
        write_reg(bpc_pkg::REG_AC3, 32'h8000);
        write_reg(bpc_pkg::REG_AC4, 32'hFFFF);
        write_reg(bpc_pkg::REG_AC5_AC6, 32'hFFFF_FFFF);
        write_reg(bpc_pkg::REG_MC_MD, 32'h8000_7FFF);
        write_reg(bpc_pkg::REG_B1_B2, 32'h7FFF_8000);
        write_reg(bpc_pkg::REG_OSS, 32'd3);
        send_request(16'hFFFF, 19'h7FFFF, 1'b0);
        send_request(16'h0000, 19'h00000, 1'b0);
        end_burst();
        drain();

        // random phases with random idling on both sides
        stall_enable = 1'b1;
        for (phase = 0; phase < 6; phase++)
        begin
            load_calibration(phase == 4);
            if (phase == 2)
                fork
                    long_hold_off();
                join_none
            for (int k = 0; k < 80; k++)
            begin
                // mostly realistic raw words, some anywhere in range
                if ($urandom_range(0, 3) != 0)
                    send_request(16'($urandom_range(20000, 35000)),
                                 19'($urandom_range(15000, 45000)) << $urandom_range(0, 3),
                                 1'b1);
                else
                    send_request(16'($urandom()), 19'($urandom()), 1'b1);
            end
            end_burst();
            drain();
        end

        if (fail_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule

FILE: files.f
rtl/bpc_pkg.sv
rtl/bpc_cfg.sv
rtl/bpc_div.sv
rtl/barometric_pressure_compensation_top.sv
verif/bpc_checker.sv
verif/tb.sv
